FILE: rtl/ikvf_pkg.sv
// Shared types, character codes and register indexes for the INI key/value finder.
`default_nettype none

package ikvf_pkg;

  localparam int DEFAULT_MAX_KEY_BYTES = 32;
  localparam int DEFAULT_POSITION_BITS = 32;

  // Key storage is always four 64-bit words, 32 bytes.
  localparam int KEY_WORDS       = 4;
  localparam int KEY_STORE_BYTES = 32;
  localparam int KEY_LEN_BITS    = 6;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 64;
  localparam int OUT_WORD_BITS   = 32;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t CFG_KEY_WORD_0 = 3'd0;
  localparam cfg_index_t CFG_KEY_WORD_1 = 3'd1;
  localparam cfg_index_t CFG_KEY_WORD_2 = 3'd2;
  localparam cfg_index_t CFG_KEY_WORD_3 = 3'd3;
  localparam cfg_index_t CFG_KEY_LENGTH = 3'd4;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [4:0] {
    PH_LEAD  = 5'b00001,
    PH_KEY   = 5'b00010,
    PH_VLEAD = 5'b00100,
    PH_VBODY = 5'b01000,
    PH_SKIP  = 5'b10000
  } line_phase_t;

endpackage

`default_nettype wire

FILE: rtl/ini_key_value_finder.sv
// Streaming INI key lookup: finds the first line whose key matches and reports its value.
`default_nettype none

// Channel   Direction  Signals                                    Request carries
// --------  ---------  -----------------------------------------  ------------------------------
// s_axis    in         s_tvalid s_tready s_tdata[7:0] s_tuser     one text byte or end marker
// m_axis    out        m_tvalid m_tready m_tdata[63:0] m_tuser    found flag, offset, length
// cfg       in         cfg_valid cfg_ready cfg_index cfg_data     one key register write
//
// The line scanner updates its state on the edge that accepts a byte, and a
// result, if any, lands on that edge in the output or skid register. The
// sustained rate is one byte per cycle while s_tready is high; it is set by the
// key byte compare and the state update, which fit between two registers.
// Reset (rst, synchronous) clears the scanner state, the key registers and the
// output side. A result waiting on a stalled m_axis does not stop input: a skid
// register catches one more result, and only while it is full is s_tready low.

module ini_key_value_finder
  import ikvf_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEFAULT_MAX_KEY_BYTES,
  parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Input byte stream.
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [7:0]                s_tdata,   // [7:0] text_byte
  input  wire logic                      s_tuser,   // [0] kind (1 = end of data)
  // Result stream.
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [63:0]                    m_tdata,   // [31:0] value_offset, [63:32] value_length
  output logic                           m_tuser,   // [0] found
  // Configuration writes.
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam logic [KEY_LEN_BITS-1:0] MAX_LEN = KEY_LEN_BITS'(MAX_KEY_BYTES);

  // Key registers.
  logic [63:0]             key_word_0;
  logic [63:0]             key_word_1;
  logic [63:0]             key_word_2;
  logic [63:0]             key_word_3;
  logic [KEY_LEN_BITS-1:0] key_length;

  // Scanner state.
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  line_phase_t              line_phase, line_phase_next;
  logic [KEY_LEN_BITS-1:0]  key_count, key_count_next;
  logic [KEY_LEN_BITS-1:0]  key_real_count, key_real_count_next;
  logic                     key_still_matches, key_still_matches_next;
  logic                     key_trailing_blank, key_trailing_blank_next;
  logic [POSITION_BITS-1:0] value_start, value_start_next;
  logic                     value_started, value_started_next;
  logic [POSITION_BITS-1:0] value_stop, value_stop_next;
  logic                     search_done, search_done_next;

  // Output register and skid register.
  logic        skid_valid;
  logic        skid_found;
  logic [63:0] skid_data;

  logic        accept;
  logic        pop;
  logic        res_valid;
  logic        res_found;
  logic [63:0] res_data;

  logic [7:0]              key_bytes [KEY_STORE_BYTES];
  logic [KEY_LEN_BITS-1:0] eff_len;
  logic                    key_ok;
  logic                    is_blank;
  logic                    is_lf;
  logic [POSITION_BITS-1:0] pos_plus_one;
  logic [POSITION_BITS-1:0] found_off;
  logic [POSITION_BITS-1:0] found_len;
  logic [63:0]             found_off_wide;
  logic [63:0]             found_len_wide;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign pop       = m_tvalid && m_tready;

  // Byte k of word w is key byte 8*w + k.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      key_bytes[k]      = key_word_0[8*k +: 8];
      key_bytes[8 + k]  = key_word_1[8*k +: 8];
      key_bytes[16 + k] = key_word_2[8*k +: 8];
      key_bytes[24 + k] = key_word_3[8*k +: 8];
    end
  end

  // A length above the configured maximum behaves as the maximum.
  assign eff_len  = (key_length > MAX_LEN) ? MAX_LEN : key_length;
  assign key_ok   = (key_count < eff_len) && (key_bytes[key_count[4:0]] == s_tdata);
  assign is_blank = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
  assign is_lf    = (s_tdata == CH_LF);
  assign pos_plus_one = byte_position + POSITION_BITS'(1);

  // A value that never saw a visible byte reports an empty value right after '='.
  assign found_off = value_started ? value_start : value_stop;
  assign found_len = value_started ? (value_stop - value_start) : '0;
  assign found_off_wide = 64'(found_off);
  assign found_len_wide = 64'(found_len);

  always_comb begin
    line_phase_t ph;
    ph                      = line_phase;
    byte_position_next      = byte_position;
    line_phase_next         = line_phase;
    key_count_next          = key_count;
    key_real_count_next     = key_real_count;
    key_still_matches_next  = key_still_matches;
    key_trailing_blank_next = key_trailing_blank;
    value_start_next        = value_start;
    value_started_next      = value_started;
    value_stop_next         = value_stop;
    search_done_next        = search_done;
    res_valid               = 1'b0;
    res_found               = 1'b0;
    res_data                = '0;

    if (accept && s_tuser) begin
      // End marker: one result unless a match was already reported, then restart.
      if (!search_done) begin
        res_valid = 1'b1;
        if (line_phase == PH_VLEAD || line_phase == PH_VBODY) begin
          res_found = 1'b1;
          res_data  = {found_len_wide[OUT_WORD_BITS-1:0], found_off_wide[OUT_WORD_BITS-1:0]};
        end
      end
      byte_position_next      = '0;
      line_phase_next         = PH_LEAD;
      key_count_next          = '0;
      key_real_count_next     = '0;
      key_still_matches_next  = 1'b1;
      key_trailing_blank_next = 1'b0;
      value_start_next        = '0;
      value_started_next      = 1'b0;
      value_stop_next         = '0;
      search_done_next        = 1'b0;
    end else if (accept) begin
      byte_position_next = pos_plus_one;
      if (!search_done) begin
        // The first visible byte of a line decides whether it is a key line;
        // a key line then handles that same byte as key text.
        if (ph == PH_LEAD && !is_lf && !is_blank) begin
          if (s_tdata == CH_SEMI || s_tdata == CH_HASH || s_tdata == CH_LBRACK) begin
            ph = PH_SKIP;
          end else begin
            ph = PH_KEY;
          end
        end
        line_phase_next = ph;

        case (ph)
          PH_KEY: begin
            if (is_lf) begin
              line_phase_next         = PH_LEAD;
              key_count_next          = '0;
              key_real_count_next     = '0;
              key_still_matches_next  = 1'b1;
              key_trailing_blank_next = 1'b0;
            end else if (s_tdata == CH_EQUAL) begin
              if (key_still_matches && key_real_count == eff_len) begin
                line_phase_next    = PH_VLEAD;
                value_stop_next    = pos_plus_one;
                value_start_next   = '0;
                value_started_next = 1'b0;
              end else begin
                line_phase_next = PH_SKIP;
              end
            end else begin
              if (is_blank || s_tdata == CH_CR) begin
                // Blanks may be trailing; they only count if they match the key.
                if (!key_ok) begin
                  key_trailing_blank_next = 1'b1;
                end
              end else begin
                key_still_matches_next  = key_still_matches && !key_trailing_blank && key_ok;
                key_trailing_blank_next = 1'b0;
                key_real_count_next     = key_count + KEY_LEN_BITS'(1);
              end
              if (key_count < MAX_LEN) begin
                key_count_next = key_count + KEY_LEN_BITS'(1);
              end
            end
          end
          PH_VLEAD, PH_VBODY: begin
            if (is_lf) begin
              res_valid        = 1'b1;
              res_found        = 1'b1;
              res_data         = {found_len_wide[OUT_WORD_BITS-1:0],
                                  found_off_wide[OUT_WORD_BITS-1:0]};
              search_done_next = 1'b1;
            end else if (!(ph == PH_VLEAD && is_blank)) begin
              if (ph == PH_VLEAD) begin
                line_phase_next  = PH_VBODY;
                value_start_next = byte_position;
              end
              if (!is_blank && s_tdata != CH_CR) begin
                value_stop_next    = pos_plus_one;
                value_started_next = 1'b1;
              end
            end
          end
          PH_SKIP: begin
            // A skipped line may have been a key line that failed at '=', so the
            // key tracking starts over for the next line.
            if (is_lf) begin
              line_phase_next         = PH_LEAD;
              key_count_next          = '0;
              key_real_count_next     = '0;
              key_still_matches_next  = 1'b1;
              key_trailing_blank_next = 1'b0;
            end
          end
          default: begin
            // Leading blanks and empty lines leave the line state as it is.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0 <= '0;
      key_word_1 <= '0;
      key_word_2 <= '0;
      key_word_3 <= '0;
      key_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_WORD_0: key_word_0 <= cfg_data;
        CFG_KEY_WORD_1: key_word_1 <= cfg_data;
        CFG_KEY_WORD_2: key_word_2 <= cfg_data;
        CFG_KEY_WORD_3: key_word_3 <= cfg_data;
        CFG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_BITS-1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      line_phase         <= PH_LEAD;
      key_count          <= '0;
      key_real_count     <= '0;
      key_still_matches  <= 1'b1;
      key_trailing_blank <= 1'b0;
      value_start        <= '0;
      value_started      <= 1'b0;
      value_stop         <= '0;
      search_done        <= 1'b0;
    end else begin
      byte_position      <= byte_position_next;
      line_phase         <= line_phase_next;
      key_count          <= key_count_next;
      key_real_count     <= key_real_count_next;
      key_still_matches  <= key_still_matches_next;
      key_trailing_blank <= key_trailing_blank_next;
      value_start        <= value_start_next;
      value_started      <= value_started_next;
      value_stop         <= value_stop_next;
      search_done        <= search_done_next;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || pop) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || pop) begin
      if (skid_valid) begin
        m_tuser <= skid_found;
        m_tdata <= skid_data;
      end else begin
        m_tuser <= res_found;
        m_tdata <= res_data;
      end
    end else if (res_valid) begin
      skid_found <= res_found;
      skid_data  <= res_data;
    end
  end

  // The skid entry only fills behind a waiting output register.
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry valid while output register empty");

  // An end marker always brings the scanner back to the start of a fresh search.
  a_end_marker_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |=> (byte_position == '0 && !search_done && line_phase == PH_LEAD))
    else $error("end marker did not restart the search");

  // A finished search parks in a value phase until the end marker.
  a_done_in_value: assert property (@(posedge clk) disable iff (rst)
    search_done |-> (line_phase == PH_VLEAD || line_phase == PH_VBODY))
    else $error("search done outside a value phase");

  // A data byte only yields a result as the newline that ends a matching line.
  a_byte_result_on_match: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !s_tuser) |-> (is_lf && !search_done &&
      (line_phase == PH_VLEAD || line_phase == PH_VBODY)))
    else $error("result from a data byte outside a matching line end");

  // After a reported match, no further result appears before the end marker.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (accept && search_done && !s_tuser) |-> !res_valid)
    else $error("second result in one search");

endmodule

`default_nettype wire

FILE: bench/ini_lookup_checker.sv
// Checker for the INI key lookup: tracks key writes and text bytes, predicts and compares results.
`timescale 1ns / 100ps

module ini_lookup_checker
  import ikvf_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  input  wire logic                      s_tready,
  input  wire logic [7:0]                s_tdata,
  input  wire logic                      s_tuser,
  input  wire logic                      m_tvalid,
  input  wire logic                      m_tready,
  input  wire logic [63:0]               m_tdata,
  input  wire logic                      m_tuser,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                             mismatches,
  output int                             answers_due
);

  localparam int KEY_CAP = DEFAULT_MAX_KEY_BYTES;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
    logic [31:0] length;
  } lookup_answer_t;

  lookup_answer_t answers_q[$];
  lookup_answer_t got, want;

  // Copy of the key registers.
  logic [CFG_DATA_BITS-1:0] key_word [KEY_WORDS];
  logic [KEY_LEN_BITS-1:0]  key_len;

  // Copy of the line scanner.
  line_phase_t phase;
  logic [31:0] byte_pos, val_start, val_end;
  logic [5:0]  key_cnt, key_real;
  logic        still_match, trail_blank, val_started, done;

  function automatic logic [5:0] key_span();
    return (key_len > KEY_CAP) ? 6'(KEY_CAP) : key_len;
  endfunction

  function automatic logic key_byte_matches(input logic [5:0] i, input logic [7:0] b);
    if (i >= key_span()) return 1'b0;
    return key_word[i[4:3]][i[2:0]*8 +: 8] == b;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB;
  endfunction

  function automatic void restart_line();
    phase       = PH_LEAD;
    key_cnt     = '0;
    key_real    = '0;
    still_match = 1'b1;
    trail_blank = 1'b0;
  endfunction

  function automatic void clear_scan();
    byte_pos    = '0;
    restart_line();
    val_start   = '0;
    val_started = 1'b0;
    val_end     = '0;
    done        = 1'b0;
  endfunction

  function automatic lookup_answer_t current_answer();
    lookup_answer_t a;
    a.found = 1'b1;
    if (val_started) begin
      a.offset = val_start;
      a.length = val_end - val_start;
    end else begin
      a.offset = val_end;
      a.length = '0;
    end
    return a;
  endfunction

  // Blanks and CRs inside the key are only trailing trim unless the key itself has them.
  function automatic void take_key_byte(input logic [7:0] b);
    logic ok;
    ok = key_byte_matches(key_cnt, b);
    if (is_blank(b) || b == CH_CR) begin
      if (!ok) trail_blank = 1'b1;
    end else begin
      still_match = still_match && !trail_blank && ok;
      trail_blank = 1'b0;
      key_real    = key_cnt + 6'd1;
    end
    if (key_cnt < KEY_CAP) key_cnt = key_cnt + 6'd1;
  endfunction

  function automatic void scan_text_byte(input logic kind, input logic [7:0] b);
    if (kind) begin
      if (!done) begin
        if (phase == PH_VLEAD || phase == PH_VBODY) answers_q.push_back(current_answer());
        else answers_q.push_back('0);
      end
      clear_scan();
    end else begin
      if (!done) begin
        if (phase == PH_LEAD) begin
          if (b == CH_LF) begin
            restart_line();
          end else if (!is_blank(b)) begin
            if (b == CH_SEMI || b == CH_HASH || b == CH_LBRACK) phase = PH_SKIP;
            else phase = PH_KEY;
          end
        end
        if (phase == PH_KEY) begin
          if (b == CH_LF) begin
            restart_line();
          end else if (b == CH_EQUAL) begin
            if (still_match && key_real == key_span()) begin
              phase       = PH_VLEAD;
              val_end     = byte_pos + 32'd1;
              val_start   = '0;
              val_started = 1'b0;
            end else begin
              phase = PH_SKIP;
            end
          end else begin
            take_key_byte(b);
          end
        end else if (phase == PH_VLEAD || phase == PH_VBODY) begin
          if (b == CH_LF) begin
            answers_q.push_back(current_answer());
            done = 1'b1;
          end else if (!(phase == PH_VLEAD && is_blank(b))) begin
            if (phase == PH_VLEAD) begin
              phase     = PH_VBODY;
              val_start = byte_pos;
            end
            if (!is_blank(b) && b != CH_CR) begin
              val_end     = byte_pos + 32'd1;
              val_started = 1'b1;
            end
          end
        end else if (phase == PH_SKIP) begin
          if (b == CH_LF) restart_line();
        end
      end
      byte_pos = byte_pos + 32'd1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (key_word[i]) key_word[i] = '0;
      key_len    = '0;
      clear_scan();
      answers_q.delete();
      mismatches = 0;
    end else begin
      // A byte accepted on the same edge as a key write still sees the old key.
      if (s_tvalid && s_tready) scan_text_byte(s_tuser, s_tdata);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < CFG_KEY_LENGTH) key_word[cfg_index[1:0]] = cfg_data;
        else if (cfg_index == CFG_KEY_LENGTH) key_len = cfg_data[KEY_LEN_BITS-1:0];
      end
      if (m_tvalid && m_tready) begin
        got.found  = m_tuser;
        got.offset = m_tdata[31:0];
        got.length = m_tdata[63:32];
        if (answers_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no lookup pending: found=%0d offset=%0d length=%0d",
                     $realtime, got.found, got.offset, got.length);
        end else begin
          want = answers_q.pop_front();
          if (got.found !== want.found || got.offset !== want.offset ||
              got.length !== want.length) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: lookup result differs: expected found=%0d offset=%0d length=%0d,",
                        " got found=%0d offset=%0d length=%0d"}, $realtime, want.found,
                       want.offset, want.length, got.found, got.offset, got.length);
          end
        end
      end
    end
    answers_due = answers_q.size();
  end

endmodule

FILE: bench/testbench.sv
// Top of the INI key lookup bench: clock, reset, key writes, text stimulus and the verdict.
`timescale 1ns / 100ps

module testbench;
  import ikvf_pkg::*;

  // Half of the 4 ns clock period.
  localparam real HALF_PERIOD = 2.0;
  // A result lands in the output register or, behind a waiting one, in the skid register,
  // so a short pause after the last result is plenty before touching the key registers.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata  = '0;
  logic                      s_tuser  = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b1;
  logic [63:0]               m_tdata;
  logic                      m_tuser;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  int mismatches;
  int answers_due;

  // Idling knobs, in percent of cycles; the stimulus process sets them per phase.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  // Asks the receiver for one long hold-off; the receiver counts it out itself.
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;

  int items_sent = 0;
  int searches   = 0;

  // The key the current phase looks for, and how many of its bytes count.
  logic [7:0] key_text [KEY_STORE_BYTES];
  int         key_eff;
  logic [7:0] text_q[$];

  always #(HALF_PERIOD) clk = ~clk;

  ini_key_value_finder DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ini_lookup_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .answers_due (answers_due)
  );

  // Result side. Outside the one long hold-off, m_tready follows the stall
  // percentage of the current phase; with a zero percentage it stays high.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 299;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Sends one request on the byte stream. It is entered and left at a falling
  // edge; idle cycles in front of it carry junk on the data lines. Valid is only
  // written once per edge, so back-to-back requests keep it high without a glitch.
  task automatic push_text(input logic kind, input logic [7:0] b);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    while (text_q.size() > 0) push_text(1'b0, text_q.pop_front());
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // One register write request. The caller drops cfg_valid after a batch.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Waits until every predicted result has come out, then lets the block drain.
  task automatic settle();
    while (answers_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A key byte never is a blank, CR, LF or '='. The first byte also avoids the
  // characters that would turn the line into a comment or a section header.
  function automatic logic [7:0] key_char(input bit first);
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'hFF));
    while (c == CH_EQUAL || (first && (c == CH_SEMI || c == CH_HASH || c == CH_LBRACK)));
    return c;
  endfunction

  function automatic logic [7:0] blank_char(input bit with_cr);
    case ($urandom_range(with_cr ? 2 : 1))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1:    return blank_char(1'b0);
      2:       return CH_CR;
      default: begin
        do c = 8'($urandom); while (c == CH_LF);
        return c;
      end
    endcase
  endfunction

  task automatic add_blanks(input int most, input bit with_cr);
    repeat ($urandom_range(most)) text_q.push_back(blank_char(with_cr));
  endtask

  // Picks a new key of the given register length; bytes past the part that
  // counts are filled with anything, so they must never take part in a match.
  task automatic pick_key(input int len);
    key_eff = (len > DEFAULT_MAX_KEY_BYTES) ? DEFAULT_MAX_KEY_BYTES : len;
    for (int i = 0; i < KEY_STORE_BYTES; i++)
      key_text[i] = (i < key_eff) ? key_char(i == 0) : 8'($urandom);
    key_eff = key_eff;
  endtask

  // Writes all four key words, the length (with junk above its six bits) and
  // one of the unused indexes, which the block has to ignore.
  task automatic write_key_regs(input int len);
    cfg_index_t             word_index [KEY_WORDS];
    logic [CFG_DATA_BITS-1:0] w;
    word_index = '{CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3};
    for (int i = 0; i < KEY_WORDS; i++) begin
      for (int k = 0; k < 8; k++) w[8*k +: 8] = key_text[8*i + k];
      write_reg(word_index[i], w);
    end
    write_reg(CFG_KEY_LENGTH, {$urandom, 26'($urandom), 6'(len)});
    write_reg(cfg_index_t'(CFG_KEY_LENGTH + 1 + $urandom_range(2)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // A "key = value" line without its newline. With exact set the key is the
  // configured one; otherwise it is a near miss: one byte changed, one byte short,
  // one byte too long (past the key cap when the key is full size), or a blank
  // slipped into the middle.
  task automatic add_key_line(input bit exact);
    logic [7:0] k[$];
    logic [7:0] c;
    int         pick, j;
    for (int i = 0; i < key_eff; i++) k.push_back(key_text[i]);
    if (!exact) begin
      pick = (k.size() == 0) ? 2 : $urandom_range(3);
      if (pick == 3 && k.size() < 2) pick = 2;
      case (pick)
        0: begin
          j = $urandom_range(k.size() - 1);
          do c = key_char(j == 0); while (c == k[j]);
          k[j] = c;
        end
        1: void'(k.pop_back());
        2: k.push_back(key_char(k.size() == 0));
        default: k.insert($urandom_range(1, k.size() - 1), blank_char(1'b0));
      endcase
    end
    add_blanks(2, 1'b0);
    foreach (k[i]) text_q.push_back(k[i]);
    add_blanks(2, 1'b1);
    text_q.push_back(CH_EQUAL);
    // Value: leading blanks, sometimes a CR that then starts the value, a short
    // body, and trailing blanks or CRs that must be trimmed off.
    add_blanks(2, 1'b0);
    if ($urandom_range(6) == 0) text_q.push_back(CH_CR);
    repeat ($urandom_range(5)) text_q.push_back(value_char());
    add_blanks(2, 1'b1);
  endtask

  // One search: a few lines, the matching one at a random place in about half
  // of them, then the end marker. Lines after a match are ignored by the block.
  // The last line sometimes has no newline, so the end marker closes it.
  task automatic send_search();
    int lines, match_at;
    lines    = $urandom_range(1, 4);
    match_at = ($urandom_range(99) < 55) ? $urandom_range(lines - 1) : -1;
    for (int i = 0; i < lines; i++) begin
      if (i == match_at) begin
        add_key_line(1'b1);
      end else begin
        case ($urandom_range(3))
          0: begin
            add_blanks(2, 1'b0);
            case ($urandom_range(2))
              0:       text_q.push_back(CH_SEMI);
              1:       text_q.push_back(CH_HASH);
              default: text_q.push_back(CH_LBRACK);
            endcase
            repeat ($urandom_range(4)) text_q.push_back(value_char());
          end
          1: begin
            add_blanks(2, 1'b0);
            repeat ($urandom_range(1, 5)) text_q.push_back(key_char(1'b1));
          end
          2: add_key_line(1'b0);
          // Raw noise: any byte value, newlines and '=' included.
          default: repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom));
        endcase
      end
      if (i < lines - 1 || $urandom_range(3) != 0) text_q.push_back(CH_LF);
    end
    send_text();
    push_text(1'b1, 8'($urandom));
    searches++;
  endtask

  // Run limit: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int key_lens [PHASES];
    int idle_tx  [4];
    int idle_rx  [4];
    int len, first_item, first_search;
    key_lens = '{5, 0, 32, 1, 63, 12, 33, 0};
    idle_tx  = '{0, 58, 0, 30};
    idle_rx  = '{0, 0, 58, 30};

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    settle();

    // Directed part, key "ab". Comment and section lines are skipped; the
    // matching line has a blank-trimmed key, a value that starts with a CR and
    // trailing blanks and CR. The end marker after the match gives no result.
    // Then "ab=" closed by the end marker: a match at end of data with an empty
    // value. A lone end marker gives not found.
    pick_key(2);
    key_text[0] = "a";
    key_text[1] = "b";
    write_key_regs(2);
    put_str("#");
    text_q.push_back(CH_LF);
    put_str(";");
    text_q.push_back(CH_LF);
    put_str("[");
    text_q.push_back(CH_LF);
    text_q.push_back(CH_SPACE);
    put_str("ab");
    text_q.push_back(CH_SPACE);
    text_q.push_back(CH_TAB);
    text_q.push_back(CH_EQUAL);
    text_q.push_back(CH_SPACE);
    text_q.push_back(CH_CR);
    put_str("v");
    text_q.push_back(CH_SPACE);
    text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
    send_text();
    push_text(1'b1, 8'h00);
    put_str("ab=");
    send_text();
    push_text(1'b1, 8'hFF);
    push_text(1'b1, 8'h5A);
    s_tvalid <= 1'b0;

    // Random phases. Each gets a new key (empty, one byte, full size, lengths
    // above the cap among them) and one of the idling patterns; the first one
    // also has the receiver hold off long enough to back the block up. It runs
    // at least three searches, so that bytes are still offered after the output
    // and skid registers have filled.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      len = (p == PHASES - 1) ? $urandom_range(2, 31) : key_lens[p];
      pick_key(len);
      write_key_regs(len);
      tx_idle_pct  = idle_tx[p % 4];
      rx_stall_pct = idle_rx[p % 4];
      if (p == 0) hold_go = 1'b1;
      first_item   = items_sent;
      first_search = searches;
      while (items_sent - first_item < 50 ||
             searches - first_search < ((p == 0) ? 3 : 2)) send_search();
      // Sometimes leave a line open, so the next key write lands mid-search.
      if (p < PHASES - 1 && $urandom_range(1) == 1) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(key_char(1'b1));
        send_text();
      end
      s_tvalid <= 1'b0;
    end

    settle();
    if (mismatches == 0 && answers_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
